// ===== rtl/http_chunked_body_decoder_core_macros.svh =====
// Assertion helpers for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHDEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHDEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/chdec_pkg.sv =====
`timescale 1ns / 1ps

package chdec_pkg;

   // Default longest size line, and the reset value of the body limit.
   localparam int          MAX_LINE_DEF     = 64;
   localparam logic [31:0] BODY_LIMIT_RESET = 32'd134217728;

   // Characters with a fixed meaning in the chunk framing.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;

   // Bytes dropped after each chunk's payload.
   localparam logic [1:0] TRAILER_LEN = 2'd2;

   // Width of the result transfer's data.
   localparam int RSP_DATA_W = 48;

   typedef enum logic [2:0] {
      PH_LINE     = 3'd0,
      PH_DATA     = 3'd1,
      PH_TRAIL    = 3'd2,
      PH_DONE     = 3'd3,
      PH_ERR_LINE = 3'd4,
      PH_ERR_BODY = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      SC_SPACE  = 2'd0,
      SC_ZERO   = 2'd1,
      SC_DIGITS = 2'd2,
      SC_STOP   = 2'd3
   } scan_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_LINE_LONG  = 2'd1,
      ERR_BODY_LARGE = 2'd2
   } err_type;

   // Size parser state: scan position, value so far and saturation flag.
   typedef struct packed {
      scan_type    scan;
      logic [31:0] value;
      logic        sat;
   } hex_state_type;

   localparam hex_state_type HEX_RESET = '{scan: SC_SPACE, value: 32'd0, sat: 1'b0};

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   // One result of the decoder.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      err_type     err;
      logic [31:0] body_length;
   } result_type;

   // Decodes one ASCII hex digit.
   function automatic digit_type hex_digit(input logic [7:0] c);
      digit_type d;
      d.ok  = 1'b0;
      d.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.ok  = 1'b1;
         d.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.ok  = 1'b1;
         d.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.ok  = 1'b1;
         d.val = 4'(c - 8'h37);
      end
      return d;
   endfunction

   // Space, TAB, LF, VT, FF and CR.
   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

// ===== rtl/chdec_hex_parse.sv =====
`timescale 1ns / 1ps

// Advances the size line parser by one character.
module chdec_hex_parse (
   input  logic                   enable,
   input  logic [7:0]             ch,
   input  chdec_pkg::hex_state_type cur,
   output chdec_pkg::hex_state_type nxt
);

   chdec_pkg::digit_type     dig;
   chdec_pkg::hex_state_type added;
   logic                     sat_new;

   assign dig = chdec_pkg::hex_digit(ch);

   // Shift in a digit, saturating once the value leaves 32 bits.
   always_comb begin
      sat_new     = cur.sat | (cur.value[31:28] != 4'd0);
      added.scan  = chdec_pkg::SC_DIGITS;
      added.sat   = sat_new;
      added.value = sat_new ? 32'hFFFF_FFFF : {cur.value[27:0], dig.val};
   end

   // Scan state update in the manner of strtoul.
   always_comb begin
      nxt = cur;
      if (enable) begin
         case (cur.scan)
            chdec_pkg::SC_SPACE: begin
               if (chdec_pkg::is_space(ch)) begin
                  nxt = cur;
               end else if (ch == chdec_pkg::CHAR_ZERO) begin
                  nxt.scan  = chdec_pkg::SC_ZERO;
                  nxt.value = 32'd0;
               end else if (dig.ok) begin
                  nxt = added;
               end else begin
                  nxt.scan = chdec_pkg::SC_STOP;
               end
            end
            chdec_pkg::SC_ZERO: begin
               if (ch == chdec_pkg::CHAR_X_LO || ch == chdec_pkg::CHAR_X_UP) begin
                  nxt.scan = chdec_pkg::SC_DIGITS;
               end else if (dig.ok) begin
                  nxt = added;
               end else begin
                  nxt.scan = chdec_pkg::SC_STOP;
               end
            end
            chdec_pkg::SC_DIGITS: begin
               if (dig.ok) begin
                  nxt = added;
               end else begin
                  nxt.scan = chdec_pkg::SC_STOP;
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

endmodule

// ===== rtl/chdec_engine.sv =====
`timescale 1ns / 1ps

// Framing state of the decoder and the result of one byte.
module chdec_engine #(
   parameter int MAX_LINE = chdec_pkg::MAX_LINE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            in_byte,
   input  logic [31:0]           body_limit,
   output chdec_pkg::result_type result
);

   localparam int                LINE_W     = $clog2(MAX_LINE);
   localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'(MAX_LINE - 1);

   chdec_pkg::phase_type     phase_ff, phase_in;
   logic [LINE_W-1:0]        line_bytes_ff, line_bytes_in;
   logic                     prev_cr_ff, prev_cr_in;
   chdec_pkg::hex_state_type hex_ff, hex_in;
   logic [31:0]              remaining_ff, remaining_in;
   logic [31:0]              offset_ff, offset_in;
   logic [1:0]               trailer_ff, trailer_in;
   logic                     final_ff, final_in;

   chdec_pkg::hex_state_type hex_mid, hex_parsed;
   logic [LINE_W-1:0]        line_inc;
   logic                     line_end, too_big, line_full;
   logic [31:0]              rem_dec;
   logic [1:0]               trail_dec;

   // A held-back CR that is not followed by LF is parsed first, then the new byte.
   chdec_hex_parse u_parse_cr (
      .enable (prev_cr_ff),
      .ch     (chdec_pkg::CHAR_CR),
      .cur    (hex_ff),
      .nxt    (hex_mid)
   );

   chdec_hex_parse u_parse_byte (
      .enable (in_byte != chdec_pkg::CHAR_CR),
      .ch     (in_byte),
      .cur    (hex_mid),
      .nxt    (hex_parsed)
   );

   // Conditions shared by the blocks below.
   always_comb begin
      line_inc  = line_bytes_ff + 1'b1;
      line_end  = prev_cr_ff && (in_byte == chdec_pkg::CHAR_LF);
      too_big   = ({1'b0, offset_ff} + {1'b0, hex_ff.value}) > {1'b0, body_limit};
      line_full = line_inc >= LINE_LIMIT;
      rem_dec   = remaining_ff - 32'd1;
      trail_dec = (trailer_ff != 2'd0) ? trailer_ff - 2'd1 : 2'd0;
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         chdec_pkg::PH_LINE: begin
            if (line_end) begin
               if (too_big) begin
                  phase_in = chdec_pkg::PH_ERR_BODY;
               end else if (hex_ff.value == 32'd0) begin
                  phase_in = chdec_pkg::PH_TRAIL;
               end else begin
                  phase_in = chdec_pkg::PH_DATA;
               end
            end else if (line_full) begin
               phase_in = chdec_pkg::PH_ERR_LINE;
            end
         end
         chdec_pkg::PH_DATA: begin
            if (rem_dec == 32'd0) begin
               phase_in = chdec_pkg::PH_TRAIL;
            end
         end
         chdec_pkg::PH_TRAIL: begin
            if (trail_dec == 2'd0) begin
               phase_in = final_ff ? chdec_pkg::PH_DONE : chdec_pkg::PH_LINE;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Result of the current byte.
   always_comb begin
      result.kind        = chdec_pkg::KIND_NONE;
      result.data        = 8'd0;
      result.err         = chdec_pkg::ERR_NONE;
      result.body_length = offset_in;
      case (phase_ff)
         chdec_pkg::PH_LINE: begin
            if (line_end && too_big) begin
               result.kind = chdec_pkg::KIND_ERROR;
               result.err  = chdec_pkg::ERR_BODY_LARGE;
            end else if (!line_end && line_full) begin
               result.kind = chdec_pkg::KIND_ERROR;
               result.err  = chdec_pkg::ERR_LINE_LONG;
            end
         end
         chdec_pkg::PH_DATA: begin
            result.kind = chdec_pkg::KIND_PAYLOAD;
            result.data = in_byte;
         end
         chdec_pkg::PH_TRAIL: begin
            if (trail_dec == 2'd0 && final_ff) begin
               result.kind = chdec_pkg::KIND_DONE;
            end
         end
         chdec_pkg::PH_ERR_LINE: begin
            result.kind = chdec_pkg::KIND_ERROR;
            result.err  = chdec_pkg::ERR_LINE_LONG;
         end
         chdec_pkg::PH_ERR_BODY: begin
            result.kind = chdec_pkg::KIND_ERROR;
            result.err  = chdec_pkg::ERR_BODY_LARGE;
         end
         default: begin
            result.kind = chdec_pkg::KIND_NONE;
         end
      endcase
   end

   // Counters, parser and chunk bookkeeping.
   always_comb begin
      line_bytes_in = line_bytes_ff;
      prev_cr_in    = prev_cr_ff;
      hex_in        = hex_ff;
      remaining_in  = remaining_ff;
      offset_in     = offset_ff;
      trailer_in    = trailer_ff;
      final_in      = final_ff;
      case (phase_ff)
         chdec_pkg::PH_LINE: begin
            line_bytes_in = line_inc;
            if (line_end) begin
               if (!too_big) begin
                  remaining_in = hex_ff.value;
                  trailer_in   = chdec_pkg::TRAILER_LEN;
                  final_in     = (hex_ff.value == 32'd0);
               end
            end else begin
               prev_cr_in = (in_byte == chdec_pkg::CHAR_CR);
               hex_in     = hex_parsed;
            end
         end
         chdec_pkg::PH_DATA: begin
            offset_in    = offset_ff + 32'd1;
            remaining_in = rem_dec;
         end
         chdec_pkg::PH_TRAIL: begin
            trailer_in = trail_dec;
            if (trail_dec == 2'd0 && !final_ff) begin
               line_bytes_in = '0;
               prev_cr_in    = 1'b0;
               hex_in        = chdec_pkg::HEX_RESET;
            end
         end
         default: begin
            offset_in = offset_ff;
         end
      endcase
   end

   // State registers advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= chdec_pkg::PH_LINE;
         line_bytes_ff <= '0;
         prev_cr_ff    <= 1'b0;
         hex_ff        <= chdec_pkg::HEX_RESET;
         remaining_ff  <= 32'd0;
         offset_ff     <= 32'd0;
         trailer_ff    <= 2'd0;
         final_ff      <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         line_bytes_ff <= line_bytes_in;
         prev_cr_ff    <= prev_cr_in;
         hex_ff        <= hex_in;
         remaining_ff  <= remaining_in;
         offset_ff     <= offset_in;
         trailer_ff    <= trailer_in;
         final_ff      <= final_in;
      end
   end

endmodule

// ===== rtl/http_chunked_body_decoder_core.sv =====
`timescale 1ns / 1ps
// A byte's result reaches the result channel through the input register and then the result
// register. Throughput: one byte per cycle
// while results are taken; each byte's framing update is one pass through the engine logic
// between the two registers, and a held result stalls the input.
// Reset (synchronous, active high) returns the decoder to the start of a size line, clears
// the body count and any held error, and sets the body limit to 134217728 bytes.

`include "http_chunked_body_decoder_core_macros.svh"

module http_chunked_body_decoder_core #(
   parameter int MAX_LINE = chdec_pkg::MAX_LINE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Body limit write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [31:0]                      csr_wdata,  // body limit
   // Raw chunked stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [7:0] in_byte
   // Decoded results.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [chdec_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [7:0] data, [9:8] error_code,
                                                        // [41:10] body_length, rest zero
   output logic [1:0]                       rsp_tuser   // [1:0] kind
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   chdec_pkg::result_type rsp_res_ff, rsp_res_in;
   logic [31:0]           body_limit_ff, body_limit_in;
   chdec_pkg::result_type step_res;
   logic                  advance;

   // A byte moves on when the result register is free or being emptied.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   chdec_engine #(
      .MAX_LINE (MAX_LINE)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (in_byte_ff),
      .body_limit (body_limit_ff),
      .result     (step_res)
   );

   // Next values of the input, result and limit registers.
   always_comb begin
      in_valid_in   = req_tready ? req_tvalid : in_valid_ff;
      in_byte_in    = (req_tvalid && req_tready) ? req_tdata : in_byte_ff;
      rsp_valid_in  = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_res_in    = advance ? step_res : rsp_res_ff;
      body_limit_in = csr_valid ? csr_wdata : body_limit_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         body_limit_ff <= chdec_pkg::BODY_LIMIT_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         body_limit_ff <= body_limit_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      rsp_res_ff <= rsp_res_in;
   end

   // Result transfer packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tdata  = {6'd0, rsp_res_ff.body_length, rsp_res_ff.err, rsp_res_ff.data};

   // Once an error is shown, every later result is an error.
   `CHDEC_ASSERT_NEXT(a_error_sticks, clock, reset,
      rsp_tvalid && rsp_tuser == chdec_pkg::KIND_ERROR,
      !rsp_tvalid || rsp_tuser == chdec_pkg::KIND_ERROR,
      "error result followed by a non-error result")

   // A payload byte has always been counted in the body length.
   `CHDEC_ASSERT_NOW(a_payload_counted, clock, reset,
      rsp_tvalid && rsp_tuser == chdec_pkg::KIND_PAYLOAD,
      rsp_tdata[41:10] != 32'd0,
      "payload result with zero body length")

   // Only error results carry an error code, only payload results carry data.
   `CHDEC_ASSERT_NOW(a_fields_clean, clock, reset,
      rsp_tvalid && rsp_tuser != chdec_pkg::KIND_ERROR,
      rsp_tdata[9:8] == chdec_pkg::ERR_NONE &&
      (rsp_tuser == chdec_pkg::KIND_PAYLOAD || rsp_tdata[7:0] == 8'd0),
      "stray error code or data on a result")

endmodule

// ===== tb/http_chunked_body_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module http_chunked_body_decoder_core_tb;
   import chdec_pkg::*;

   localparam int          LINE_LIMIT  = MAX_LINE_DEF;
   localparam int          ITEM_GOAL   = 2000;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          OPEN_ROWS   = 25;

   // Characters the generator and the decoder model need beyond the package set.
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A_LO  = 8'h61;
   localparam logic [7:0] CHAR_F_LO  = 8'h66;
   localparam logic [7:0] CHAR_A_UP  = 8'h41;
   localparam logic [7:0] CHAR_F_UP  = 8'h46;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_Z_LO  = 8'h7A;
   localparam logic [7:0] CHAR_G_LO  = 8'h67;

   typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_type;
   typedef enum {END_COMPLETE, END_LINE_LONG, END_SIZE_OVERFLOW, END_LIMIT} ending_type;

   // One row of the opening script; typed rows carry their own expected result.
   typedef struct packed {
      logic [7:0]  in_byte;
      logic        typed;
      kind_type    kind;
      logic [7:0]  data;
      err_type     err;
      logic [31:0] body_length;
   } script_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [31:0]           csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // Opening script: a size line with a lone CR and 0X prefix, payload extremes,
   // then a second chunk with leading LF and TAB, leading zeros and an extension.
   script_row_type opening_script [OPEN_ROWS] = '{
      '{CHAR_SPACE, 1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_VT,    1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_ZERO,  1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_X_UP,  1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{8'h32,      1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_SEMI,  1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_CR,    1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_Z_LO,  1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_CR,    1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{CHAR_LF,    1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd0},
      '{8'h00,      1'b1, KIND_PAYLOAD, 8'h00, ERR_NONE, 32'd1},
      '{8'hFF,      1'b1, KIND_PAYLOAD, 8'hFF, ERR_NONE, 32'd2},
      '{8'hFF,      1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{8'h00,      1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{CHAR_LF,    1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{CHAR_TAB,   1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{CHAR_ZERO,  1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{CHAR_ZERO,  1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{8'h31,      1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{CHAR_G_LO,  1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{CHAR_CR,    1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{CHAR_LF,    1'b0, KIND_NONE,    8'h00, ERR_NONE, 32'd2},
      '{8'h5A,      1'b1, KIND_PAYLOAD, 8'h5A, ERR_NONE, 32'd3},
      '{CHAR_CR,    1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd3},
      '{CHAR_LF,    1'b1, KIND_NONE,    8'h00, ERR_NONE, 32'd3}
   };

   // Decoder model state.
   phase_type   dec_phase      = PH_LINE;
   int          dec_line_bytes = 0;
   bit          dec_cr_held    = 1'b0;
   scan_type    dec_scan       = SC_SPACE;
   logic [31:0] dec_size       = '0;
   bit          dec_size_sat   = 1'b0;
   logic [31:0] dec_left       = '0;
   logic [31:0] dec_body       = '0;
   logic [1:0]  dec_trail      = '0;
   bit          dec_last_chunk = 1'b0;
   logic [31:0] dec_limit      = BODY_LIMIT_RESET;

   result_type  awaited_results [$];
   logic [7:0]  outgoing_bytes [$];

   int          burst_left     = 0;
   bit          quiet          = 1'b0;
   int          items_sent     = 0;
   int          chunks_sent    = 0;
   int          limit_writes   = 0;
   int          results_seen   = 0;
   int          fail_count     = 0;
   int          cycle_count    = 0;
   ending_type  ending         = END_COMPLETE;

   http_chunked_body_decoder_core #(
      .MAX_LINE (LINE_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hex value of a character, or -1 when it is not a hex digit.
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_A_LO && c <= CHAR_F_LO) return int'(c - CHAR_A_LO) + 10;
      if (c >= CHAR_A_UP && c <= CHAR_F_UP) return int'(c - CHAR_A_UP) + 10;
      return -1;
   endfunction

   // Appends one digit to the chunk size, sticking at all ones once it overflows.
   function automatic void shift_nibble(input int nib);
      logic [35:0] wide;
      wide = {dec_size, 4'(nib)};
      if (dec_size_sat || wide[35:32] != 4'd0) begin
         dec_size_sat = 1'b1;
         dec_size     = '1;
      end else begin
         dec_size = wide[31:0];
      end
   endfunction

   // Size line parsing: skip white space, optional 0x, digits, then stop for good.
   function automatic void scan_char(input logic [7:0] c);
      int nib;
      nib = nibble_of(c);
      case (dec_scan)
         SC_SPACE: begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
               // Leading white space is skipped.
            end else if (c == CHAR_ZERO) begin
               dec_scan = SC_ZERO;
               dec_size = '0;
            end else if (nib >= 0) begin
               dec_scan = SC_DIGITS;
               shift_nibble(nib);
            end else begin
               dec_scan = SC_STOP;
            end
         end
         SC_ZERO: begin
            if (c == CHAR_X_LO || c == CHAR_X_UP) begin
               dec_scan = SC_DIGITS;
            end else if (nib >= 0) begin
               dec_scan = SC_DIGITS;
               shift_nibble(nib);
            end else begin
               dec_scan = SC_STOP;
            end
         end
         SC_DIGITS: begin
            if (nib >= 0) shift_nibble(nib);
            else dec_scan = SC_STOP;
         end
         default: ;
      endcase
   endfunction

   function automatic void restart_line();
      dec_line_bytes = 0;
      dec_cr_held    = 1'b0;
      dec_scan       = SC_SPACE;
      dec_size       = '0;
      dec_size_sat   = 1'b0;
   endfunction

   // Advances the decoder model by one stream byte and returns its result.
   function automatic result_type decode_byte(input logic [7:0] c);
      result_type r;
      r = '{kind: KIND_NONE, data: 8'h00, err: ERR_NONE, body_length: 32'd0};
      case (dec_phase)
         PH_LINE: begin
            dec_line_bytes++;
            if (dec_cr_held && c == CHAR_LF) begin
               if (33'(dec_body) + 33'(dec_size) > 33'(dec_limit)) begin
                  dec_phase = PH_ERR_BODY;
                  r.kind    = KIND_ERROR;
                  r.err     = ERR_BODY_LARGE;
               end else begin
                  dec_left       = dec_size;
                  dec_trail      = TRAILER_LEN;
                  dec_last_chunk = (dec_size == 32'd0);
                  dec_phase      = dec_last_chunk ? PH_TRAIL : PH_DATA;
               end
            end else begin
               // A held CR that is not part of CR LF belongs to the line.
               if (dec_cr_held) scan_char(CHAR_CR);
               dec_cr_held = (c == CHAR_CR);
               if (!dec_cr_held) scan_char(c);
               if (dec_line_bytes >= LINE_LIMIT - 1) begin
                  dec_phase = PH_ERR_LINE;
                  r.kind    = KIND_ERROR;
                  r.err     = ERR_LINE_LONG;
               end
            end
         end
         PH_DATA: begin
            r.kind   = KIND_PAYLOAD;
            r.data   = c;
            dec_body = dec_body + 32'd1;
            dec_left = dec_left - 32'd1;
            if (dec_left == 32'd0) dec_phase = PH_TRAIL;
         end
         PH_TRAIL: begin
            if (dec_trail != 2'd0) dec_trail = dec_trail - 2'd1;
            if (dec_trail == 2'd0) begin
               if (dec_last_chunk) begin
                  dec_phase = PH_DONE;
                  r.kind    = KIND_DONE;
               end else begin
                  dec_phase = PH_LINE;
                  restart_line();
               end
            end
         end
         PH_ERR_LINE: begin
            r.kind = KIND_ERROR;
            r.err  = ERR_LINE_LONG;
         end
         PH_ERR_BODY: begin
            r.kind = KIND_ERROR;
            r.err  = ERR_BODY_LARGE;
         end
         default: ;
      endcase
      r.body_length = dec_body;
      return r;
   endfunction

   // One byte transfer on the input stream, with bursts and gaps.
   task automatic push_byte(input logic [7:0] b, input bit typed, input result_type typed_res);
      result_type predicted;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = quiet ? 4096 : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
      predicted = decode_byte(b);
      awaited_results.push_back(typed ? typed_res : predicted);
   endtask

   task automatic flush_bytes();
      while (outgoing_bytes.size() != 0) push_byte(outgoing_bytes.pop_front(), 1'b0, '0);
   endtask

   // Writes the body limit once the decoder has drained.
   task automatic write_limit(input logic [31:0] v);
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      dec_limit = v;
      limit_writes++;
   endtask

   // Queues a byte, never letting a CR be followed by LF inside a line.
   function automatic void append_safe(input logic [7:0] b);
      if (outgoing_bytes.size() != 0 && outgoing_bytes[$] == CHAR_CR && b == CHAR_LF)
         b = CHAR_SPACE;
      outgoing_bytes.push_back(b);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return CHAR_ZERO + nib;
      return ($urandom_range(0, 1) ? CHAR_A_LO : CHAR_A_UP) + nib - 8'd10;
   endfunction

   function automatic void queue_digits(input logic [31:0] value, input int count);
      for (int k = count - 1; k >= 0; k--) outgoing_bytes.push_back(hex_char(4'(value >> (4 * k))));
   endfunction

   function automatic void queue_white(input int count);
      logic [7:0] b;
      repeat (count) begin
         case ($urandom_range(0, 5))
            0: b = CHAR_SPACE;
            1: b = CHAR_TAB;
            2: b = CHAR_LF;
            3: b = CHAR_VT;
            4: b = CHAR_FF;
            default: b = CHAR_CR;
         endcase
         append_safe(b);
      end
   endfunction

   // Size line for a nonzero size: white space, optional prefix, mixed-case digits,
   // optional extension of random bytes. A full line uses the longest legal length.
   function automatic void queue_size_line(input int unsigned n, input bit full);
      int         start;
      int         nd;
      int         ext;
      logic [7:0] b;
      start = outgoing_bytes.size();
      queue_white($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         1: begin
            outgoing_bytes.push_back(CHAR_ZERO);
            outgoing_bytes.push_back(CHAR_X_LO);
         end
         2: begin
            outgoing_bytes.push_back(CHAR_ZERO);
            outgoing_bytes.push_back(CHAR_X_UP);
         end
         3: repeat ($urandom_range(1, 3)) outgoing_bytes.push_back(CHAR_ZERO);
         default: ;
      endcase
      nd = 1;
      while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
      queue_digits(n, nd);
      if (full) ext = LINE_LIMIT - 3 - (outgoing_bytes.size() - start);
      else ext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (ext > 0) begin
         do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
         append_safe(b);
         repeat (ext - 1) append_safe(8'($urandom_range(0, 255)));
      end
      outgoing_bytes.push_back(CHAR_CR);
      outgoing_bytes.push_back(CHAR_LF);
   endfunction

   // Input side: reset, opening script, random chunk phases, then one ending.
   initial begin : stimulus
      int unsigned      chunk_sizes [$];
      int unsigned      planned;
      int unsigned      n;
      longint unsigned  floor_v;
      longint unsigned  span;
      logic [31:0]      limit_v;
      result_type       typed_res;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Opening script, run with the reset body limit.
      foreach (opening_script[i]) begin
         typed_res = '{kind: opening_script[i].kind, data: opening_script[i].data,
                       err: opening_script[i].err, body_length: opening_script[i].body_length};
         push_byte(opening_script[i].in_byte, opening_script[i].typed, typed_res);
      end

      // Phases of well-formed chunks; the limit is rewritten while drained.
      while (items_sent < ITEM_GOAL) begin
         chunk_sizes.delete();
         planned = 0;
         repeat ($urandom_range(1, 6)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
            chunk_sizes.push_back(n);
            planned += n;
         end
         floor_v = longint'(dec_body) + planned;
         case ($urandom_range(0, 3))
            0: limit_v = '1;
            // Exactly enough: the last chunk lands on the limit.
            1: limit_v = floor_v[31:0];
            2: begin
               span    = 64'h1_0000_0000 - floor_v;
               limit_v = 32'(floor_v + (longint'($urandom()) % span));
            end
            default: limit_v = BODY_LIMIT_RESET;
         endcase
         write_limit(limit_v);
         quiet      = ($urandom_range(0, 4) == 0);
         burst_left = 0;
         foreach (chunk_sizes[k]) begin
            queue_size_line(chunk_sizes[k], $urandom_range(0, 15) == 0);
            repeat (chunk_sizes[k]) outgoing_bytes.push_back(8'($urandom_range(0, 255)));
            repeat (TRAILER_LEN) outgoing_bytes.push_back(8'($urandom_range(0, 255)));
            flush_bytes();
            chunks_sent++;
         end
      end

      // The stream ends in one of the terminal states; nothing leaves them but reset.
      quiet  = 1'b0;
      ending = ending_type'($urandom_range(0, 3));
      case (ending)
         END_COMPLETE: begin
            queue_white($urandom_range(0, 2));
            case ($urandom_range(0, 4))
               0: outgoing_bytes.push_back(CHAR_ZERO);
               1: begin
                  outgoing_bytes.push_back(CHAR_ZERO);
                  outgoing_bytes.push_back(CHAR_X_LO);
                  outgoing_bytes.push_back(CHAR_ZERO);
               end
               // A sign is not a digit, so the size reads as zero.
               2: begin
                  outgoing_bytes.push_back(CHAR_MINUS);
                  queue_digits($urandom(), $urandom_range(1, 3));
               end
               3: begin
                  outgoing_bytes.push_back(CHAR_PLUS);
                  queue_digits($urandom(), $urandom_range(1, 3));
               end
               default: begin
                  outgoing_bytes.push_back(CHAR_ZERO);
                  outgoing_bytes.push_back(CHAR_X_UP);
               end
            endcase
            outgoing_bytes.push_back(CHAR_CR);
            outgoing_bytes.push_back(CHAR_LF);
            repeat (TRAILER_LEN) outgoing_bytes.push_back(8'($urandom_range(0, 255)));
         end
         END_LINE_LONG: begin
            queue_white($urandom_range(0, 2));
            queue_digits($urandom(), $urandom_range(1, 4));
            while (outgoing_bytes.size() < LINE_LIMIT + 8)
               append_safe(8'($urandom_range(0, 255)));
         end
         END_SIZE_OVERFLOW: begin
            write_limit('1);
            outgoing_bytes.push_back(8'h31);
            repeat ($urandom_range(8, 12))
               outgoing_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
            outgoing_bytes.push_back(CHAR_CR);
            outgoing_bytes.push_back(CHAR_LF);
         end
         default: begin
            // Body already holds payload, so a zero limit or one byte short must fail.
            n = $urandom_range(1, 20);
            write_limit($urandom_range(0, 1) ? 32'd0 : dec_body + n - 32'd1);
            queue_size_line(n, 1'b0);
         end
      endcase
      repeat (8) outgoing_bytes.push_back(8'($urandom_range(0, 255)));
      flush_bytes();
      req_tvalid <= 1'b0;

      // Drain, then give the pipeline time to show any stray result.
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_results.size());
         fail_count++;
      end
      $display("Sent %0d bytes in %0d random chunks after the opening script, %0d limit writes.",
               items_sent, chunks_sent, limit_writes);
      $display("Checked %0d results; the stream ended by %s.", results_seen, ending.name());
      if (fail_count == 0) begin
         $display("[http_chunked_body_decoder_core] OK");
      end else begin
         $display("[http_chunked_body_decoder_core] ERROR");
      end
      $finish;
   end

   // Result side: check each transfer against the oldest expectation, then pick
   // the next ready value from a stall pattern chosen at random: open, random or periodic.
   always @(posedge clock) begin : rsp_side
      result_type  want;
      rx_mode_type rx_mode;
      int          rx_tick;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, kind %0d data %02h error %0d length %0d", $time,
                     rsp_tuser, rsp_tdata[7:0], rsp_tdata[9:8], rsp_tdata[41:10]);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            results_seen++;
            if (rsp_tuser !== want.kind) begin
               $display("%0t: kind expected %0d, actual %0d", $time, want.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[7:0] !== want.data) begin
               $display("%0t: data expected %02h, actual %02h", $time, want.data, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[9:8] !== want.err) begin
               $display("%0t: error code expected %0d, actual %0d", $time, want.err,
                        rsp_tdata[9:8]);
               fail_count++;
            end
            if (rsp_tdata[41:10] !== want.body_length) begin
               $display("%0t: body length expected %0d, actual %0d", $time, want.body_length,
                        rsp_tdata[41:10]);
               fail_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:42] !== '0) begin
               $display("%0t: pad bits expected 0, actual %h", $time,
                        rsp_tdata[RSP_DATA_W-1:42]);
               fail_count++;
            end
         end
      end
      if (rx_tick % 64 == 0) rx_mode = rx_mode_type'($urandom_range(0, 2));
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:   rsp_tready <= (rx_tick % 16 >= 5);
      endcase
      rx_tick++;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
         $display("[http_chunked_body_decoder_core] ERROR");
         $finish;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/chdec_pkg.sv
rtl/chdec_hex_parse.sv
rtl/chdec_engine.sv
rtl/http_chunked_body_decoder_core.sv
tb/http_chunked_body_decoder_core_tb.sv
